>>> src/tcs_pkg.sv
// ----------------------------------------------------------------------------
// Time-compression schedule package
// Shared widths, register indexes, phase codes, result type and tail ramp.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int unsigned FW         = 11;
  localparam int unsigned MAX_FRAMES = 1024;
  localparam int unsigned REG_IW     = 3;
  localparam int unsigned TPS_W      = 6;

  localparam logic [REG_IW-1:0] REG_TOTAL  = 3'd0;
  localparam logic [REG_IW-1:0] REG_START  = 3'd1;
  localparam logic [REG_IW-1:0] REG_STOP   = 3'd2;
  localparam logic [REG_IW-1:0] REG_HSTEP  = 3'd3;
  localparam logic [REG_IW-1:0] REG_TMODE  = 3'd4;

  typedef enum logic [1:0] {
    PH_HEAD   = 2'd0,
    PH_DETAIL = 2'd1,
    PH_TAIL   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [FW-1:0] total;
    logic [FW-1:0] start;
    logic [FW-1:0] stop;
    logic [FW-1:0] head_step;
    logic          tail_mode;
  } cfg_t;

  typedef struct packed {
    logic [FW-1:0] point_index;
    logic [FW-1:0] point_size;
    logic [FW-1:0] offset_in_point;
    logic [9:0]    weight_numerator;
    logic [9:0]    point_first_frame;
    logic [FW-1:0] centre_twice;
    logic          in_tail;
    logic          last_of_point;
    logic          past_end;
  } res_t;

  // floor((2k+15)/10) capped at 8: one step more at k = 3, 8, 13, ... 33
  function automatic logic [3:0] tail_ramp(input logic [TPS_W-1:0] k);
    logic [3:0] r;
    r = 4'd1;
    for (int i = 0; i < 7; i++) begin
      if (k >= TPS_W'(3 + 5 * i)) r = r + 4'd1;
    end
    return r;
  endfunction

endpackage

>>> src/tcs_if.sv
// ----------------------------------------------------------------------------
// Time-compression schedule channels
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
interface tcs_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface tcs_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] point_index;
  logic [10:0] point_size;
  logic [10:0] offset_in_point;
  logic [9:0]  weight_numerator;
  logic [9:0]  point_first_frame;
  logic [10:0] centre_twice;
  logic        in_tail;
  logic        last_of_point;
  logic        past_end;
  modport source (output valid, output point_index, output point_size,
                  output offset_in_point, output weight_numerator,
                  output point_first_frame, output centre_twice, output in_tail,
                  output last_of_point, output past_end, input ready);
  modport sink (input valid, input point_index, input point_size,
                input offset_in_point, input weight_numerator,
                input point_first_frame, input centre_twice, input in_tail,
                input last_of_point, input past_end, output ready);
endinterface

interface tcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/tcs_cfg.sv
// ----------------------------------------------------------------------------
// Time-compression schedule registers
// Holds the five registers and presents clamped totals and bounds.
// ----------------------------------------------------------------------------
module tcs_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [tcs_pkg::REG_IW-1:0] wr_index,
  input  logic [tcs_pkg::FW-1:0]    wr_data,
  output tcs_pkg::cfg_t             cfg
);
  import tcs_pkg::*;

  logic [FW-1:0] total_r, start_r, stop_r, hstep_r;
  logic          tmode_r;
  logic [FW-1:0] tot, s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      start_r <= '0;
      stop_r  <= '0;
      hstep_r <= FW'(1);
      tmode_r <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TOTAL: total_r <= wr_data;
        REG_START: start_r <= wr_data;
        REG_STOP:  stop_r  <= wr_data;
        REG_HSTEP: hstep_r <= wr_data;
        REG_TMODE: tmode_r <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tot = (total_r > FW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : total_r;
    s   = (start_r > tot) ? tot : start_r;
    cfg.total     = tot;
    cfg.start     = s;
    cfg.stop      = (stop_r < s) ? s : ((stop_r > tot) ? tot : stop_r);
    cfg.head_step = (hstep_r == '0) ? FW'(1) : hstep_r;
    cfg.tail_mode = tmode_r;
  end

endmodule

>>> src/tcs_sched.sv
// ----------------------------------------------------------------------------
// Time-compression schedule tracker
// Advances frame and point state by one tick and forms the tick's result.
// ----------------------------------------------------------------------------
module tcs_sched (
  input  logic          clk,
  input  logic          rst_n,
  input  tcs_pkg::cfg_t cfg,
  input  logic          take,
  input  logic          restart,
  output tcs_pkg::res_t res
);
  import tcs_pkg::*;

  phase_t           phase_r, phase_nxt, e_phase;
  logic [FW-1:0]    point_r, point_nxt, e_point;
  logic [FW-1:0]    size_r, size_nxt, e_size;
  logic [FW-1:0]    pos_r, pos_nxt, e_pos;
  logic [9:0]       first_r, first_nxt;
  logic [FW-1:0]    step_r, step_nxt, e_step;
  logic [TPS_W-1:0] tps_r, tps_nxt, e_tps;
  logic [FW-1:0]    fc_r, fc_nxt, e_fc;

  logic             past, open;
  logic [FW-1:0]    head_left, tail_left, hsize, tsize, step0, std_step, wdiff;
  logic [TPS_W-1:0] tps0, tps1;
  logic [FW:0]      step_sum;

  always_comb begin
    e_fc    = restart ? '0 : fc_r;
    e_size  = restart ? '0 : size_r;
    e_point = restart ? '0 : point_r;
    e_pos   = restart ? '0 : pos_r;
    e_phase = restart ? PH_HEAD : phase_r;
    e_tps   = restart ? '0 : tps_r;
    e_step  = restart ? FW'(2) : step_r;

    past = (e_fc >= cfg.total);
    open = (e_size == '0) || (e_pos >= e_size);

    head_left = cfg.start - e_fc;
    tail_left = cfg.total - e_fc;
    hsize     = (cfg.head_step < head_left) ? cfg.head_step : head_left;

    step0 = (e_phase != PH_TAIL) ? (cfg.tail_mode ? FW'(1) : FW'(2)) : e_step;
    tps0  = (e_phase != PH_TAIL) ? '0 : e_tps;
    tps1  = (tps0 == '1) ? tps0 : tps0 + TPS_W'(1);
    step_sum = {1'b0, step0} + (FW+1)'(4);
    std_step = (step_sum > (FW+1)'(2047)) ? FW'(2047) : step_sum[FW-1:0];
    tsize    = (step0 < tail_left) ? step0 : tail_left;

    phase_nxt = e_phase;
    point_nxt = e_point;
    size_nxt  = e_size;
    pos_nxt   = e_pos;
    first_nxt = first_r;
    step_nxt  = e_step;
    tps_nxt   = e_tps;
    fc_nxt    = e_fc;

    if (!past) begin
      fc_nxt  = e_fc + FW'(1);
      pos_nxt = e_pos + FW'(1);
      if (open) begin
        point_nxt = (e_size == '0) ? '0 : e_point + FW'(1);
        first_nxt = e_fc[9:0];
        pos_nxt   = FW'(1);
        if (e_fc < cfg.start) begin
          phase_nxt = PH_HEAD;
          size_nxt  = hsize;
        end else if (e_fc < cfg.stop) begin
          phase_nxt = PH_DETAIL;
          size_nxt  = FW'(1);
        end else begin
          phase_nxt = PH_TAIL;
          size_nxt  = tsize;
          tps_nxt   = tps1;
          step_nxt  = cfg.tail_mode ? FW'(tail_ramp(tps1)) : std_step;
        end
      end
    end

    wdiff = size_nxt - pos_nxt;
    res   = '0;
    if (past) begin
      res.past_end = 1'b1;
    end else begin
      res.point_index       = point_nxt;
      res.point_size        = size_nxt;
      res.offset_in_point   = pos_nxt;
      res.weight_numerator  = wdiff[9:0];
      res.point_first_frame = first_nxt;
      res.centre_twice      = {first_nxt, 1'b0} + size_nxt - FW'(1);
      res.in_tail           = (phase_nxt == PH_TAIL);
      res.last_of_point     = (pos_nxt == size_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      point_r <= '0;
      size_r  <= '0;
      pos_r   <= '0;
      first_r <= '0;
      step_r  <= FW'(2);
      tps_r   <= '0;
      fc_r    <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      point_r <= point_nxt;
      size_r  <= size_nxt;
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
      step_r  <= step_nxt;
      tps_r   <= tps_nxt;
      fc_r    <= fc_nxt;
    end
  end

endmodule

>>> src/tcs_outq.sv
// ----------------------------------------------------------------------------
// Time-compression schedule result buffer
// Output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module tcs_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcs_pkg::res_t push_data,
  output logic          can_push,
  output logic          head_valid,
  input  logic          pop,
  output tcs_pkg::res_t head_data
);
  import tcs_pkg::*;

  logic main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;
  res_t main_r, main_nxt, skid_r, skid_nxt;

  assign can_push   = !skid_v_r;
  assign head_valid = main_v_r;
  assign head_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = push;
        skid_nxt   = push_data;
      end else begin
        main_v_nxt = push;
        main_nxt   = push_data;
      end
    end else if (!main_v_r) begin
      main_v_nxt = push;
      main_nxt   = push_data;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> src/time_compression_schedule_top.sv
// ----------------------------------------------------------------------------
// Time-compression schedule top level
// Maps each frame tick to its compressed point: head, detail and tail phases.
//
//   channel  dir   payload                              request
//   in_ch    in    restart                              one frame tick
//   out_ch   out   point fields, in_tail, last, past    one tick result
//   cfg_ch   in    index, data                          one register write
//
// A request is taken every cycle while the skid entry is free; its result is
// registered in the output register, or in the skid entry if the output is held.
// A stalled output holds two results, then the input stalls.
// Reset is synchronous: registers return to their defaults, schedule to frame 0.
// Register writes are always taken.
// ----------------------------------------------------------------------------
module time_compression_schedule_top (
  input logic        clk,
  input logic        rst_n,
  tcs_in_if.sink     in_ch,
  tcs_out_if.source  out_ch,
  tcs_cfg_if.sink    cfg_ch
);
  import tcs_pkg::*;

  cfg_t cfg;
  res_t res, head;
  logic can_push, take, head_valid, pop;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = can_push;
  assign take         = in_ch.valid && can_push;
  assign pop          = head_valid && out_ch.ready;

  tcs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  tcs_sched u_sched (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .take    (take),
    .restart (in_ch.restart),
    .res     (res)
  );

  tcs_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_data  (res),
    .can_push   (can_push),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head)
  );

  assign out_ch.valid             = head_valid;
  assign out_ch.point_index       = head.point_index;
  assign out_ch.point_size        = head.point_size;
  assign out_ch.offset_in_point   = head.offset_in_point;
  assign out_ch.weight_numerator  = head.weight_numerator;
  assign out_ch.point_first_frame = head.point_first_frame;
  assign out_ch.centre_twice      = head.centre_twice;
  assign out_ch.in_tail           = head.in_tail;
  assign out_ch.last_of_point     = head.last_of_point;
  assign out_ch.past_end          = head.past_end;

  a_past_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.past_end |-> out_ch.point_size == '0 &&
      out_ch.offset_in_point == '0 && !out_ch.last_of_point)
    else $error("past_end result carries point data");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.past_end |->
      out_ch.offset_in_point != '0 && out_ch.offset_in_point <= out_ch.point_size)
    else $error("offset outside its point");

  a_weight: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.past_end && out_ch.last_of_point |->
      out_ch.weight_numerator == '0)
    else $error("nonzero weight on last frame of point");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty output");

endmodule
